[design/mtfb_pkg.sv]
// ---------------------------------------------------------------------------
// mtfb_pkg
// Shared constants and types of the Modbus TCP float frame builder.
// ---------------------------------------------------------------------------
package mtfb_pkg;

	localparam int FRAME_LEN  = 29;
	localparam int NUM_LANES  = 4;
	localparam int FLOAT_BASE = 13;

	// 53-bit significand of the double nearest to 3.3
	localparam logic [52:0] SCALE_MANT = 53'h1A666666666666;

	localparam logic [7:0] MBAP_LENGTH      = 8'h17;
	localparam logic [7:0] FUNC_WRITE_MULTI = 8'h10;
	localparam logic [7:0] REG_QUANTITY     = 8'h08;
	localparam logic [7:0] PAYLOAD_BYTES    = 8'h10;

	localparam logic [4:0] POS_TXN_HI   = 5'd0;
	localparam logic [4:0] POS_TXN_LO   = 5'd1;
	localparam logic [4:0] POS_PROTO_HI = 5'd2;
	localparam logic [4:0] POS_PROTO_LO = 5'd3;
	localparam logic [4:0] POS_LEN_HI   = 5'd4;
	localparam logic [4:0] POS_LEN_LO   = 5'd5;
	localparam logic [4:0] POS_UNIT     = 5'd6;
	localparam logic [4:0] POS_FUNC     = 5'd7;
	localparam logic [4:0] POS_START_HI = 5'd8;
	localparam logic [4:0] POS_START_LO = 5'd9;
	localparam logic [4:0] POS_QTY_HI   = 5'd10;
	localparam logic [4:0] POS_QTY_LO   = 5'd11;
	localparam logic [4:0] POS_BCOUNT   = 5'd12;
	localparam logic [4:0] POS_LAST     = 5'd28;

	localparam logic CFG_UNIT_IDENT     = 1'b0;
	localparam logic CFG_REGISTER_START = 1'b1;

	typedef struct packed {
		logic [15:0]      txn;
		logic [3:0][31:0] floats;
	} frame_t;

	typedef struct packed {
		logic [7:0]  unit;
		logic [15:0] start;
	} hdr_cfg_t;

endpackage

[design/modbus_tcp_float_frame_builder_core.sv]
// ---------------------------------------------------------------------------
// modbus_tcp_float_frame_builder_core
// Builds a 29-byte Modbus TCP write-multiple-registers frame of four
// scaled floats from one input transaction.
// ---------------------------------------------------------------------------
// Usage:
//   input channel (in_valid/in_stall) takes a transaction number and four
//   converter counts. output channel (out_valid/out_stall) gives 29
//   transactions, one frame byte each with its position, last_byte on 28.
//   cfg_we/cfg_index/cfg_data write unit_ident (0) and register_start (1)
//   while idle; both are read live while the frame goes out.
//   Four conversion lanes run in parallel; the first byte is offered once
//   their results are registered and loaded into the byte serializer.
//   The byte serializer sends the frame out byte by byte; the next input
//   is accepted as soon as the previous result moves into the
//   serializer, so frames follow back to back while out_stall is low.
//   A stalled receiver holds the current byte; the input then stalls once
//   one further item waits behind the frame being sent.
//   Reset clears all control state; unit_ident returns to 1 and
//   register_start to 0.
// ---------------------------------------------------------------------------
module modbus_tcp_float_frame_builder_core #(
	parameter int COUNT_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [15:0]           transaction_number,
	input  logic [COUNT_BITS-1:0] battery_current_count,
	input  logic [COUNT_BITS-1:0] upper_current_count,
	input  logic [COUNT_BITS-1:0] lower_current_count,
	input  logic [COUNT_BITS-1:0] battery_voltage_count,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            frame_byte,
	output logic [4:0]            byte_position,
	output logic                  last_byte,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [15:0]           cfg_data
);

	mtfb_pkg::hdr_cfg_t cfg_q;
	mtfb_pkg::frame_t   frame_in;
	logic [15:0]        txn_q;
	logic               pend_q, res_q;
	logic               accept, load, ending;
	logic [3:0]         done;
	logic [3:0][31:0]   bits;
	logic [3:0][COUNT_BITS-1:0] counts;

	assign accept   = in_valid & ~in_stall;
	assign in_stall = pend_q;
	assign load     = res_q & (~out_valid | ending);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.unit  <= 8'd1;
			cfg_q.start <= 16'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				mtfb_pkg::CFG_UNIT_IDENT:     cfg_q.unit  <= cfg_data[7:0];
				mtfb_pkg::CFG_REGISTER_START: cfg_q.start <= cfg_data;
				default: ;
			endcase
		end
	end

	// one item in the lanes or waiting for the serializer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			res_q  <= 1'b0;
		end else begin
			if (accept) pend_q <= 1'b1;
			else if (load) pend_q <= 1'b0;
			if (done[0]) res_q <= 1'b1;
			else if (load) res_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) txn_q <= transaction_number;
	end

	assign counts = {battery_voltage_count, lower_current_count,
		upper_current_count, battery_current_count};

	for (genvar g = 0; g < mtfb_pkg::NUM_LANES; g++) begin : g_lane
		mtfb_lane #(.COUNT_BITS(COUNT_BITS)) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (accept),
			.count  (counts[g]),
			.done   (done[g]),
			.bits   (bits[g])
		);
	end

	assign frame_in.txn    = txn_q;
	assign frame_in.floats = bits;

	mtfb_serializer u_ser (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (load),
		.frame_in      (frame_in),
		.cfg           (cfg_q),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.ending        (ending),
		.frame_byte    (frame_byte),
		.byte_position (byte_position),
		.last_byte     (last_byte)
	);

`ifndef SYNTHESIS
	a_lanes_agree: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(done) == 1'b0 || done == 4'hF || done == 4'h0)
		else $error("lanes out of step");
	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("second item accepted while one is pending");
	a_load_starts: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (out_valid && byte_position == 5'd0))
		else $error("frame did not start at position zero");
	a_no_lost_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_q |-> pend_q)
		else $error("result without pending item");
`endif

endmodule

[design/mtfb_lane.sv]
// ---------------------------------------------------------------------------
// mtfb_lane
// Converts one converter count to IEEE single volts (count*3.3/4096),
// rounding to double first and then to single, in a five stage pipeline.
// ---------------------------------------------------------------------------
module mtfb_lane #(
	parameter int COUNT_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [COUNT_BITS-1:0] count,
	output logic                  done,
	output logic [31:0]           bits
);

	localparam int PW = COUNT_BITS + 53;
	localparam int LW = $clog2(PW);

	logic [COUNT_BITS+26:0] lo_s1;
	logic [COUNT_BITS+25:0] hi_s1;
	logic [PW-1:0]          prod_s2;
	logic [PW-1:0]          norm_s3;
	logic [7:0]             exp_s3;
	logic [52:0]            md_s4;
	logic [7:0]             ed_s4;
	logic [31:0]            bits_s5;
	logic                   zero_s1, zero_s2, zero_s3, zero_s4;
	logic                   v_s1, v_s2, v_s3, v_s4, v_s5;

	logic [LW-1:0] lead;
	logic [52:0]   dm;
	logic          dg, dst, dup;
	logic [53:0]   dsum;
	logic [23:0]   sm;
	logic          sg, sst, sup;
	logic [24:0]   ssum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// leading one of the exact product
	always_comb begin
		lead = '0;
		for (int i = 0; i < PW; i++) begin
			if (prod_s2[i]) lead = LW'(i);
		end
	end

	always_comb begin
		dm   = norm_s3[PW-1 -: 53];
		dg   = norm_s3[PW-54];
		dst  = |norm_s3[PW-55:0];
		dup  = dg & (dst | dm[0]);
		dsum = {1'b0, dm} + 54'(dup);
		sm   = md_s4[52:29];
		sg   = md_s4[28];
		sst  = |md_s4[27:0];
		sup  = sg & (sst | sm[0]);
		ssum = {1'b0, sm} + 25'(sup);
	end

	always_ff @(posedge clk) begin
		lo_s1   <= count * mtfb_pkg::SCALE_MANT[26:0];
		hi_s1   <= count * mtfb_pkg::SCALE_MANT[52:27];
		zero_s1 <= (count == '0);

		prod_s2 <= {hi_s1, 27'b0} + PW'(lo_s1);
		zero_s2 <= zero_s1;

		// product is scaled by 2^-63 in total
		norm_s3 <= prod_s2 << (LW'(PW - 1) - lead);
		exp_s3  <= 8'(lead) + 8'd64;
		zero_s3 <= zero_s2;

		if (dsum[53]) begin
			md_s4 <= dsum[53:1];
			ed_s4 <= exp_s3 + 8'd1;
		end else begin
			md_s4 <= dsum[52:0];
			ed_s4 <= exp_s3;
		end
		zero_s4 <= zero_s3;

		// result is held until the next transaction reaches the last stage
		if (v_s4) begin
			if (zero_s4)
				bits_s5 <= '0;
			else if (ssum[24])
				bits_s5 <= {1'b0, ed_s4 + 8'd1, 23'd0};
			else
				bits_s5 <= {1'b0, ed_s4, ssum[22:0]};
		end
	end

	assign done = v_s5;
	assign bits = bits_s5;

endmodule

[design/mtfb_serializer.sv]
// ---------------------------------------------------------------------------
// mtfb_serializer
// Merges the lane results and header fields into a frame and sends it
// one byte per transaction.
// ---------------------------------------------------------------------------
module mtfb_serializer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  mtfb_pkg::frame_t   frame_in,
	input  mtfb_pkg::hdr_cfg_t cfg,
	input  logic               out_stall,
	output logic               out_valid,
	output logic               ending,
	output logic [7:0]         frame_byte,
	output logic [4:0]         byte_position,
	output logic               last_byte
);

	mtfb_pkg::frame_t frame_q;
	logic             busy_q;
	logic [4:0]       pos_q;
	logic [4:0]       off;
	logic [31:0]      fsel;
	logic             adv;

	assign adv    = busy_q & ~out_stall;
	assign ending = adv & (pos_q == mtfb_pkg::POS_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			pos_q  <= '0;
		end else if (adv) begin
			busy_q <= (pos_q != mtfb_pkg::POS_LAST);
			pos_q  <= pos_q + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) frame_q <= frame_in;
	end

	always_comb begin
		off  = pos_q - 5'(mtfb_pkg::FLOAT_BASE);
		fsel = frame_q.floats[off[3:2]];
		case (pos_q)
			mtfb_pkg::POS_TXN_HI:   frame_byte = frame_q.txn[15:8];
			mtfb_pkg::POS_TXN_LO:   frame_byte = frame_q.txn[7:0];
			mtfb_pkg::POS_PROTO_HI: frame_byte = 8'h00;
			mtfb_pkg::POS_PROTO_LO: frame_byte = 8'h00;
			mtfb_pkg::POS_LEN_HI:   frame_byte = 8'h00;
			mtfb_pkg::POS_LEN_LO:   frame_byte = mtfb_pkg::MBAP_LENGTH;
			mtfb_pkg::POS_UNIT:     frame_byte = cfg.unit;
			mtfb_pkg::POS_FUNC:     frame_byte = mtfb_pkg::FUNC_WRITE_MULTI;
			mtfb_pkg::POS_START_HI: frame_byte = cfg.start[15:8];
			mtfb_pkg::POS_START_LO: frame_byte = cfg.start[7:0];
			mtfb_pkg::POS_QTY_HI:   frame_byte = 8'h00;
			mtfb_pkg::POS_QTY_LO:   frame_byte = mtfb_pkg::REG_QUANTITY;
			mtfb_pkg::POS_BCOUNT:   frame_byte = mtfb_pkg::PAYLOAD_BYTES;
			default: begin
				// word-swapped float bytes: CDAB
				case (off[1:0])
					2'd0:    frame_byte = fsel[15:8];
					2'd1:    frame_byte = fsel[7:0];
					2'd2:    frame_byte = fsel[31:24];
					default: frame_byte = fsel[23:16];
				endcase
			end
		endcase
	end

	assign out_valid     = busy_q;
	assign byte_position = pos_q;
	assign last_byte     = (pos_q == mtfb_pkg::POS_LAST);

endmodule
